// ===== design/modular_inverse_ext_euclid_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for modular_inverse_ext_euclid
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked on clk, disabled while rst_n is low.
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, also checked during reset.
`define MIE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MIE_ASSERT(lbl, prop, msg)
`define MIE_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types for the modular inverse controller and datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Extra bits on Bezout coefficients beyond the value width (sign + margin).
  localparam int unsigned COEF_GUARD_BITS = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH
  } state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;         // capture input transaction
    logic div_start;    // start one quotient step
    logic align_shift;  // shift divisor up one bit
    logic sub_step;     // one restoring compare/subtract bit
    logic out_load;     // write result register
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic r_zero;      // remainder is zero, algorithm done
    logic align_more;  // divisor can still be doubled
    logic k_zero;      // last quotient bit of this step
  } status_t;

endpackage

// ===== design/mie_ctrl.sv =====
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the extended Euclid steps and the result handshake.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mie_pkg::status_t status,
  output mie_pkg::cmd_t    cmd
);

  mie_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mie_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_CHECK: begin
        if (status.r_zero) begin
          state_nxt = mie_pkg::ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = mie_pkg::ST_ALIGN;
        end
      end
      mie_pkg::ST_ALIGN: begin
        if (status.align_more) begin
          cmd.align_shift = 1'b1;
        end else begin
          state_nxt = mie_pkg::ST_SUB;
        end
      end
      mie_pkg::ST_SUB: begin
        cmd.sub_step = 1'b1;
        if (status.k_zero) begin
          state_nxt = mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mie_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/mie_datapath.sv =====
// ----------------------------------------------------------------------------
// mie_datapath
// Remainder/coefficient registers, shift-subtract divider, result register.
// ----------------------------------------------------------------------------
module mie_datapath #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk,
  input  mie_pkg::cmd_t         cmd,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [VALUE_BITS-1:0] in_modulus,
  output mie_pkg::status_t      status,
  output logic [VALUE_BITS-1:0] out_inverse,
  output logic [VALUE_BITS-1:0] out_divisor,
  output logic                  out_invertible
);

  localparam int unsigned W  = VALUE_BITS;
  localparam int unsigned CW = VALUE_BITS + mie_pkg::COEF_GUARD_BITS;
  localparam int unsigned KW = $clog2(VALUE_BITS);

  // Euclid state
  logic [W-1:0]         old_r_r, r_r, m_r;
  logic signed [CW-1:0] old_s_r, s_r;
  // Division of old_r by r, with the coefficient update folded in
  logic [W-1:0]         rem_r, d_r;
  logic signed [CW-1:0] ns_r, sd_r;
  logic [KW-1:0]        k_r;
  // Result
  logic [W-1:0]         inverse_r, divisor_r;
  logic                 invertible_r;

  logic                 ge;
  logic [W-1:0]         rem_sub;
  logic signed [CW-1:0] ns_sub;
  logic signed [CW-1:0] m_ext, c_plus, c_minus, c_norm;
  logic [W-1:0]         inv_val;

  assign ge      = (rem_r >= d_r);
  assign rem_sub = ge ? (rem_r - d_r) : rem_r;
  assign ns_sub  = ge ? (ns_r - sd_r) : ns_r;

  assign status.r_zero     = (r_r == '0);
  assign status.align_more = ({d_r, 1'b0} <= {1'b0, rem_r});
  assign status.k_zero     = (k_r == '0);

  // coefficient lies in [-m, m]; one correction brings it into [0, m-1]
  assign m_ext   = signed'({{mie_pkg::COEF_GUARD_BITS{1'b0}}, m_r});
  assign c_plus  = old_s_r + m_ext;
  assign c_minus = old_s_r - m_ext;
  always_comb begin
    if (old_s_r[CW-1]) begin
      c_norm = c_plus;
    end else if (old_s_r >= m_ext) begin
      c_norm = c_minus;
    end else begin
      c_norm = old_s_r;
    end
  end
  assign inv_val = (m_r == '0) ? '0 : c_norm[W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_r_r <= in_value;
      r_r     <= in_modulus;
      m_r     <= in_modulus;
      old_s_r <= CW'(1);
      s_r     <= '0;
    end
    if (cmd.div_start) begin
      rem_r <= old_r_r;
      d_r   <= r_r;
      ns_r  <= old_s_r;
      sd_r  <= s_r;
      k_r   <= '0;
    end
    if (cmd.align_shift) begin
      d_r  <= {d_r[W-2:0], 1'b0};
      sd_r <= sd_r <<< 1;
      k_r  <= k_r + KW'(1);
    end
    if (cmd.sub_step) begin
      rem_r <= rem_sub;
      ns_r  <= ns_sub;
      d_r   <= {1'b0, d_r[W-1:1]};
      sd_r  <= sd_r >>> 1;
      k_r   <= k_r - KW'(1);
      if (k_r == '0) begin
        // quotient complete: rotate the Euclid pairs
        old_r_r <= r_r;
        r_r     <= rem_sub;
        old_s_r <= s_r;
        s_r     <= ns_sub;
      end
    end
    if (cmd.out_load) begin
      inverse_r    <= inv_val;
      divisor_r    <= old_r_r;
      invertible_r <= (old_r_r == W'(1));
    end
  end

  assign out_inverse    = inverse_r;
  assign out_divisor    = divisor_r;
  assign out_invertible = invertible_r;

endmodule

// ===== design/modular_inverse_ext_euclid.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse, gcd and coprime flag by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// One transaction in (value, modulus) gives one transaction out (inverse,
// divisor, invertible). The block handles one item at a time: in_ready is
// high only while idle. Each Euclid step divides the running remainders with
// a shift-subtract divider that first shifts the divisor up to the dividend
// one bit at a time and then takes one quotient bit per cycle, after a check
// of the remainder for zero; the coefficient update rides on the same shifts,
// no multiplier. The result sits in an output register, so a result that is
// not yet taken only holds the engine after the next item finishes.
// A modulus of 1 gives inverse 0; a modulus of 0 gives divisor = value and
// inverse 0. When the gcd is not 1, inverse carries the normalized Bezout
// coefficient and invertible is low.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [VALUE_BITS-1:0] in_modulus,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VALUE_BITS-1:0] out_inverse,
  output logic [VALUE_BITS-1:0] out_divisor,
  output logic                  out_invertible
);

  `include "modular_inverse_ext_euclid_assert.svh"

  mie_pkg::cmd_t    cmd;
  mie_pkg::status_t status;

  // sequencer: accept, step loop, result handshake
  mie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Euclid registers, divider and result register
  mie_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .in_value       (in_value),
    .in_modulus     (in_modulus),
    .status         (status),
    .out_inverse    (out_inverse),
    .out_divisor    (out_divisor),
    .out_invertible (out_invertible)
  );

  // Assertions ---------------------------------------------------------------

  // one item in flight: no accept right after an accept
  `MIE_ASSERT(a_single_item, (in_valid && in_ready) |=> !in_ready, "second accept while busy")

  // a pending result is never overwritten
  `MIE_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid || out_ready), "result overwritten")

  // the controller issues at most one datapath command per cycle
  `MIE_ASSERT(a_cmd_onehot,
    $onehot0({cmd.load, cmd.div_start, cmd.align_shift, cmd.sub_step, cmd.out_load}),
    "conflicting datapath commands")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: modular_inverse_ext_euclid testbench
// Sends (value, modulus) transactions over the valid/ready input channel.
// Each accepted transaction is run through a local extended Euclid
// predictor, and every result transaction is compared in order with its
// expectation. A directed set covers the edge cases. Random phases then run
// with different mixes of sender idling and receiver stalls, and one long
// receiver hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned VB           = 31;
  localparam int unsigned FIELD_MAX    = 32'h7FFF_FFFF;
  localparam int unsigned LONG_HOLD    = 400;   // cycles of receiver hold-off
  localparam int unsigned TAIL_CYCLES  = 200;   // longer than the worst engine latency
  localparam int unsigned REPORT_LIMIT = 10;

  // One expected result transaction.
  typedef struct packed {
    logic [VB-1:0] inverse;
    logic [VB-1:0] divisor;
    logic          invertible;
  } inv_result_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [VB-1:0] in_value;
  logic [VB-1:0] in_modulus;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [VB-1:0] out_inverse;
  logic [VB-1:0] out_divisor;
  logic          out_invertible;

  inv_result_t pending_results[$];   // expectations in acceptance order
  inv_result_t want;
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;   // chance per cycle that the sender idles
  int unsigned recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  logic        receiver_hold  = 1'b0;
  event        long_hold_ev;

  modular_inverse_ext_euclid #(
    .VALUE_BITS(VB)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .in_modulus    (in_modulus),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inverse   (out_inverse),
    .out_divisor   (out_divisor),
    .out_invertible(out_invertible)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: iterative extended Euclid on (value, modulus). Coefficients
  // live in 64-bit signed ints; their magnitude never exceeds max(value, modulus)
  // so nothing overflows. The coefficient of value is then folded into
  // [0, modulus-1]. A zero modulus skips the loop: gcd is the value itself.
  // --------------------------------------------------------------------------
  function automatic inv_result_t euclid_inverse(input logic [VB-1:0] value,
                                                 input logic [VB-1:0] modulus);
    inv_result_t res;
    longint      rem_prev, rem_cur, coef_prev, coef_cur, quot, tmp, mod_l, mag;
    mod_l = longint'({33'd0, modulus});
    if (modulus == '0) begin
      res.inverse    = '0;
      res.divisor    = value;
      res.invertible = (value == VB'(1));
      return res;
    end
    rem_prev  = longint'({33'd0, value});
    rem_cur   = mod_l;
    coef_prev = 1;
    coef_cur  = 0;
    while (rem_cur != 0) begin
      quot      = rem_prev / rem_cur;
      tmp       = rem_prev - quot * rem_cur;
      rem_prev  = rem_cur;
      rem_cur   = tmp;
      tmp       = coef_prev - quot * coef_cur;
      coef_prev = coef_cur;
      coef_cur  = tmp;
    end
    if (coef_prev < 0) begin
      mag = (-coef_prev) % mod_l;
      res.inverse = (mag == 0) ? '0 : VB'(mod_l - mag);
    end else begin
      res.inverse = VB'(coef_prev % mod_l);
    end
    res.divisor    = VB'(rem_prev);
    res.invertible = (rem_prev == 1);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: drives out_ready (random stalls plus the long hold-off) and
  // checks each accepted result transaction against the oldest expectation.
  // Values are sampled at the edge, before any NBA of that step lands.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: inv=%0d gcd=%0d flag=%0b",
                     $realtime, out_inverse, out_divisor, out_invertible);
        end else begin
          want = pending_results.pop_front();
          if (out_inverse !== want.inverse || out_divisor !== want.divisor ||
              out_invertible !== want.invertible) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch exp inv=%0d gcd=%0d flag=%0b, got inv=%0d gcd=%0d flag=%0b",
                       $realtime, want.inverse, want.divisor, want.invertible,
                       out_inverse, out_divisor, out_invertible);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering meanwhile.
  always begin
    @(long_hold_ev);
    receiver_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender: one transaction. Called at a clock edge, returns at the edge
  // where the transaction is accepted. Valid is only lowered when an idle
  // cycle is taken, so back-to-back items keep it high.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [VB-1:0] value, input logic [VB-1:0] modulus);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_value   <= value;
    in_modulus <= modulus;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(euclid_inverse(value, modulus));
  endtask

  // Random operand pair; mixes full range, short operands, shared factors,
  // value above modulus, modulus near the top, modulus one and value zero.
  task automatic send_random_item();
    int unsigned kind, w, g, v, m;
    kind = $urandom_range(99);
    if (kind < 40) begin
      m = $urandom_range(FIELD_MAX, 1);
      v = $urandom & FIELD_MAX;
    end else if (kind < 58) begin
      w = $urandom_range(16, 2);
      m = $urandom_range((1 << w) - 1, 1);
      v = $urandom_range((1 << w) - 1, 0);
    end else if (kind < 73) begin
      g = $urandom_range(1000, 2);
      m = g * $urandom_range(FIELD_MAX / g, 1);
      v = g * $urandom_range(FIELD_MAX / g, 0);
    end else if (kind < 84) begin
      m = $urandom_range(65535, 1);
      v = $urandom & FIELD_MAX;
    end else if (kind < 92) begin
      m = FIELD_MAX - $urandom_range(255, 0);
      v = $urandom & FIELD_MAX;
    end else if (kind < 96) begin
      m = 1;
      v = $urandom & FIELD_MAX;
    end else begin
      m = $urandom_range(FIELD_MAX, 1);
      v = 0;
    end
    send_item(VB'(v), VB'(m));
  endtask

  // Sender pause: nothing offered until every expected result is back.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int unsigned idle_pct,
                                  input int unsigned stall_pct,
                                  input int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
    wait_all_results();
  endtask

  // Edge cases: modulus one, value zero, extremes, not coprime, value above
  // modulus, worst-case Euclid (consecutive Fibonacci), modulus zero.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(31'd0, 31'd1);
    send_item(31'd1, 31'd1);
    send_item(31'h7FFF_FFFF, 31'd1);
    send_item(31'd0, 31'h7FFF_FFFF);
    send_item(31'd0, 31'd12);
    send_item(31'd1, 31'h7FFF_FFFF);
    send_item(31'h7FFF_FFFE, 31'h7FFF_FFFF);
    send_item(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(31'h7FFF_FFFF, 31'h7FFF_FFFE);
    send_item(31'd3, 31'd7);
    send_item(31'd10, 31'd7);
    send_item(31'd6, 31'd9);
    send_item(31'd12, 31'd18);
    send_item(31'd1, 31'd2);
    send_item(31'd2, 31'h7FFF_FFFF);
    send_item(31'h4000_0000, 31'h7FFF_FFFF);
    send_item(31'h4000_0000, 31'h2000_0000);
    send_item(31'd1134903170, 31'd1836311903);
    send_item(31'd1836311903, 31'd1134903170);
    send_item(31'h5555_5555, 31'h2AAA_AAAA);
    send_item(31'd1, 31'd0);
    send_item(31'd5, 31'd0);
    send_item(31'd0, 31'd0);
    wait_all_results();
  endtask

  task automatic test_random_no_idle();
    run_random_phase(0, 0, 250);
  endtask

  task automatic test_random_sender_idle();
    run_random_phase(79, 0, 250);
  endtask

  task automatic test_random_receiver_stall();
    run_random_phase(0, 79, 250);
  endtask

  task automatic test_random_both_idle();
    run_random_phase(22, 22, 250);
  endtask

  // Receiver holds off while the sender streams: the output register and the
  // engine fill, in_ready drops, and the input stalls until the hold ends.
  task automatic test_long_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> long_hold_ev;
    repeat (12) send_random_item();
    wait_all_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_value   = '0;
    in_modulus = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_long_stall();
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("modular_inverse_ext_euclid test passed");
    end else begin
      $display("modular_inverse_ext_euclid test failed");
    end
    $finish;
  end

  // Watchdog: nominal run is a few ms; this is roughly ten times that.
  initial begin
    #40_000_000;
    $display("modular_inverse_ext_euclid test failed");
    $finish;
  end

endmodule
